// ===== design/setl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setl_pkg: shared types and constants for the sorted expiry timer list
// Operation and status codes, FSM states and the controller/datapath links.
// ----------------------------------------------------------------------------
package setl_pkg;

    localparam int DEF_TIMERS    = 64;
    localparam int DEF_TIME_BITS = 32;
    localparam int ID_W          = 6;
    localparam int ID_SPACE      = 64;
    localparam int IN_TIME_W     = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INSERT
    } t_state;

    typedef struct packed {
        logic load;        // capture the incoming item
        logic insert;      // sorted insert of the held id and expiry
        logic remove;      // take the held id out of the order
        logic pop;         // take the head entry out of the order
        logic set_present;
        logic clr_present;
    } t_dp_cmd;

    typedef struct packed {
        t_op             op;
        logic            present;
        logic            full;
        logic            head_due;
        logic            next_due;
        logic [ID_W-1:0] head_id;
    } t_dp_stat;

endpackage

// ===== design/setl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setl_datapath: ordered compare-and-shift store of timers
// Each slot compares its expiry in parallel and shifts toward or away from
// the head; holds the presence bits and the captured item.
// ----------------------------------------------------------------------------
module setl_datapath #(
    parameter int TIMERS    = setl_pkg::DEF_TIMERS,
    parameter int TIME_BITS = setl_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  setl_pkg::t_dp_cmd              i_cmd,
    input  logic [1:0]                     i_op,
    input  logic [setl_pkg::ID_W-1:0]      i_id,
    input  logic [setl_pkg::IN_TIME_W-1:0] i_expire,
    input  logic [setl_pkg::IN_TIME_W-1:0] i_now,
    output setl_pkg::t_dp_stat             o_stat
);
    localparam int CNT_W = $clog2(TIMERS + 1);

    logic [setl_pkg::ID_W-1:0] r_ids [TIMERS];
    logic [TIME_BITS-1:0]      r_exp [TIMERS];
    logic [setl_pkg::ID_W-1:0] n_ids [TIMERS];
    logic [TIME_BITS-1:0]      n_exp [TIMERS];
    logic [CNT_W-1:0]          r_count, n_count;
    logic [setl_pkg::ID_SPACE-1:0] r_present;

    setl_pkg::t_op             r_op;
    logic [setl_pkg::ID_W-1:0] r_id;
    logic [TIME_BITS-1:0]      r_new_exp;
    logic [TIME_BITS-1:0]      r_now;

    logic [TIMERS-1:0] w_later;   // slot empty or its expiry is after the new one
    logic [TIMERS-1:0] w_shift;   // slot takes its successor on removal

    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < TIMERS; i++) begin
            w_later[i] = (CNT_W'(i) >= r_count) || (r_exp[i] > r_new_exp);
            acc        = acc || (i_cmd.pop) ||
                         ((CNT_W'(i) < r_count) && (r_ids[i] == r_id));
            w_shift[i] = acc;
        end
    end

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < TIMERS; i++) begin
            n_ids[i] = r_ids[i];
            n_exp[i] = r_exp[i];
        end
        if (i_cmd.insert) begin
            n_count = r_count + CNT_W'(1);
            for (int i = 0; i < TIMERS; i++) begin
                if (i > 0 && w_later[(i > 0) ? i - 1 : 0]) begin
                    n_ids[i] = r_ids[(i > 0) ? i - 1 : 0];
                    n_exp[i] = r_exp[(i > 0) ? i - 1 : 0];
                end else if (w_later[i]) begin
                    n_ids[i] = r_id;
                    n_exp[i] = r_new_exp;
                end
            end
        end else if (i_cmd.remove || i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
            for (int i = 0; i < TIMERS - 1; i++) begin
                if (w_shift[i]) begin
                    n_ids[i] = r_ids[i + 1];
                    n_exp[i] = r_exp[i + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TIMERS; i++) begin
            r_ids[i] <= n_ids[i];
            r_exp[i] <= n_exp[i];
        end
        if (i_cmd.load) begin
            r_op      <= setl_pkg::t_op'(i_op);
            r_id      <= i_id;
            r_new_exp <= TIME_BITS'(i_expire);
            r_now     <= TIME_BITS'(i_now);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_present <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.set_present) begin
                r_present[r_id] <= 1'b1;
            end else if (i_cmd.clr_present) begin
                r_present[i_cmd.pop ? r_ids[0] : r_id] <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.present  = r_present[r_id];
        o_stat.full     = (r_count == CNT_W'(TIMERS));
        o_stat.head_due = (r_count != '0) && (r_exp[0] <= r_now);
        o_stat.next_due = (r_count > CNT_W'(1)) && (r_exp[1] <= r_now);
        o_stat.head_id  = r_ids[0];
    end

endmodule

// ===== design/setl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setl_ctrl: operation sequencer and result register
// Decodes the captured operation, issues datapath commands and holds one
// result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module setl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_exp_valid,
    output logic [setl_pkg::ID_W-1:0] o_exp_id,
    output logic                      o_last,
    output setl_pkg::t_dp_cmd         o_cmd,
    input  setl_pkg::t_dp_stat        i_stat
);
    setl_pkg::t_state r_state, n_state;

    logic                      r_out_valid;
    setl_pkg::t_status         r_status, w_status;
    logic                      r_exp_valid, w_exp_valid;
    logic [setl_pkg::ID_W-1:0] r_exp_id, w_exp_id;
    logic                      r_last, w_last;
    logic                      w_emit;
    logic                      w_free;

    assign w_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            setl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = setl_pkg::S_EXEC;
            end
            setl_pkg::S_EXEC: begin
                if (w_free) begin
                    unique case (i_stat.op)
                        setl_pkg::OP_ADJUST: begin
                            n_state = i_stat.present ? setl_pkg::S_INSERT : setl_pkg::S_IDLE;
                        end
                        setl_pkg::OP_TICK: begin
                            if (!(i_stat.head_due && i_stat.next_due)) begin
                                n_state = setl_pkg::S_IDLE;
                            end
                        end
                        default: n_state = setl_pkg::S_IDLE;
                    endcase
                end
            end
            setl_pkg::S_INSERT: begin
                if (w_free) n_state = setl_pkg::S_IDLE;
            end
            default: n_state = setl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        w_emit      = 1'b0;
        w_status    = setl_pkg::ST_OK;
        w_exp_valid = 1'b0;
        w_exp_id    = '0;
        w_last      = 1'b1;
        unique case (r_state)
            setl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            setl_pkg::S_EXEC: begin
                if (w_free) begin
                    unique case (i_stat.op)
                        setl_pkg::OP_ADD: begin
                            w_emit = 1'b1;
                            if (i_stat.present || i_stat.full) begin
                                w_status = setl_pkg::ST_REJECT;
                            end else begin
                                o_cmd.insert      = 1'b1;
                                o_cmd.set_present = 1'b1;
                            end
                        end
                        setl_pkg::OP_ADJUST: begin
                            if (!i_stat.present) begin
                                w_emit   = 1'b1;
                                w_status = setl_pkg::ST_ABSENT;
                            end else begin
                                o_cmd.remove = 1'b1;
                            end
                        end
                        setl_pkg::OP_DELETE: begin
                            w_emit = 1'b1;
                            if (!i_stat.present) begin
                                w_status = setl_pkg::ST_ABSENT;
                            end else begin
                                o_cmd.remove      = 1'b1;
                                o_cmd.clr_present = 1'b1;
                            end
                        end
                        setl_pkg::OP_TICK: begin
                            w_emit = 1'b1;
                            if (i_stat.head_due) begin
                                o_cmd.pop         = 1'b1;
                                o_cmd.clr_present = 1'b1;
                                w_exp_valid       = 1'b1;
                                w_exp_id          = i_stat.head_id;
                                w_last            = !i_stat.next_due;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            setl_pkg::S_INSERT: begin
                if (w_free) begin
                    o_cmd.insert = 1'b1;
                    w_emit       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= setl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_status    <= w_status;
            r_exp_valid <= w_exp_valid;
            r_exp_id    <= w_exp_id;
            r_last      <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_exp_valid = r_exp_valid;
    assign o_exp_id    = r_exp_id;
    assign o_last      = r_last;

endmodule

// ===== design/sorted_expiry_timer_list_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_list_core: timers kept in ascending expiry order
// Add, adjust, delete and tick operations on an ordered shift store.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  s_axis   in   tdata: op, timer_id, expire_time, now_time
//  m_axis   out  tdata: status, expired_valid, expired_id; tlast: last
//
//  Add, delete and failed operations give their result from the execute
//  state; adjust removes there, then inserts sorted and gives its result
//  from the insert state. A tick gives one result per cycle per expired
//  timer while the output is free, each a single-slot shift of the store.
//  A new item is taken in idle. Reset is synchronous; the store needs no
//  clearing pass. A stalled result holds the sequencer until it is taken.
module sorted_expiry_timer_list_core #(
    parameter int TIMERS    = setl_pkg::DEF_TIMERS,
    parameter int TIME_BITS = setl_pkg::DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // op, timer_id, expire_time, now_time
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status, expired_valid, expired_id, zeros
    output logic        m_axis_tlast
);
    setl_pkg::t_dp_cmd         w_cmd;
    setl_pkg::t_dp_stat        w_stat;
    logic [1:0]                w_status;
    logic                      w_exp_valid;
    logic [setl_pkg::ID_W-1:0] w_exp_id;

    setl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_exp_valid (w_exp_valid),
        .o_exp_id    (w_exp_id),
        .o_last      (m_axis_tlast),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    setl_datapath #(
        .TIMERS    (TIMERS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_op     (s_axis_tdata[1:0]),
        .i_id     (s_axis_tdata[7:2]),
        .i_expire (s_axis_tdata[39:8]),
        .i_now    (s_axis_tdata[71:40]),
        .o_stat   (w_stat)
    );

    assign m_axis_tdata = {7'd0, w_exp_id, w_exp_valid, w_status};

endmodule

// ===== dv/sorted_expiry_timer_list_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_list_core_tb: self-checking bench for the timer list
// Feeds add, adjust, delete and tick items, predicts the ordered list in a
// local copy and compares every result item field by field, in order.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_list_core_tb;

    localparam int TIMERS    = 64;
    localparam int WDOG_MAX  = 20000;
    localparam int TAIL_WAIT = 20;
    localparam int N_RANDOM  = 46;

    typedef struct packed {
        setl_pkg::t_op op;
        logic [5:0]    id;
        logic [31:0]   expiry;
        logic [31:0]   now;
    } t_cmd;

    typedef struct packed {
        setl_pkg::t_status status;
        logic              exp_valid;
        logic [5:0]        exp_id;
        logic              last;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;    // op, timer_id, expire_time, now_time
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // status, expired_valid, expired_id, zeros
    logic        m_axis_tlast;

    sorted_expiry_timer_list_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Predicted timer list.
    logic [5:0]  list_ids[$];
    logic [31:0] list_exp[$];
    logic        present[64];

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   expiries_seen = 0;
    int   items_sent = 0;
    int   wdog = 0;
    bit   stim_done = 0;
    bit   noidle = 0;
    bit   hold_rx = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res mk_res(setl_pkg::t_status s, logic v, logic [5:0] id, logic l);
        t_res r;
        r.status = s;
        r.exp_valid = v;
        r.exp_id = id;
        r.last = l;
        return r;
    endfunction

    function automatic void list_insert(logic [5:0] id, logic [31:0] ex);
        int p;
        p = 0;
        while (p < list_exp.size() && list_exp[p] <= ex) p++;
        list_ids.insert(p, id);
        list_exp.insert(p, ex);
    endfunction

    function automatic void list_remove(logic [5:0] id);
        for (int i = 0; i < list_ids.size(); i++) begin
            if (list_ids[i] == id) begin
                list_ids.delete(i);
                list_exp.delete(i);
                return;
            end
        end
    endfunction

    // Applies one accepted item to the predicted list and queues its results.
    function automatic void predict_timer_op(t_cmd c);
        int n;
        n = 0;
        case (c.op)
            setl_pkg::OP_ADD: begin
                if (present[c.id] || list_ids.size() >= TIMERS) begin
                    expected_results.push_back(mk_res(setl_pkg::ST_REJECT, 0, 0, 1));
                end else begin
                    list_insert(c.id, c.expiry);
                    present[c.id] = 1;
                    expected_results.push_back(mk_res(setl_pkg::ST_OK, 0, 0, 1));
                end
            end
            setl_pkg::OP_ADJUST, setl_pkg::OP_DELETE: begin
                if (!present[c.id]) begin
                    expected_results.push_back(mk_res(setl_pkg::ST_ABSENT, 0, 0, 1));
                end else begin
                    list_remove(c.id);
                    if (c.op == setl_pkg::OP_ADJUST) list_insert(c.id, c.expiry);
                    else present[c.id] = 0;
                    expected_results.push_back(mk_res(setl_pkg::ST_OK, 0, 0, 1));
                end
            end
            default: begin
                while (list_ids.size() > 0 && list_exp[0] <= c.now) begin
                    expected_results.push_back(mk_res(setl_pkg::ST_OK, 1, list_ids[0], 0));
                    present[list_ids[0]] = 0;
                    list_ids.delete(0);
                    list_exp.delete(0);
                    n++;
                end
                if (n == 0) expected_results.push_back(mk_res(setl_pkg::ST_OK, 0, 0, 1));
                else expected_results[$].last = 1;
            end
        endcase
    endfunction

    function automatic void queue_cmd(setl_pkg::t_op op, logic [5:0] id, logic [31:0] ex,
                                      logic [31:0] now);
        t_cmd c;
        c.op = op;
        c.id = id;
        c.expiry = ex;
        c.now = now;
        pending_cmds.push_back(c);
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_timer_op(t_cmd'({s_axis_tdata[1:0], s_axis_tdata[7:2],
                                         s_axis_tdata[39:8], s_axis_tdata[71:40]}));
                items_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (pending_cmds.size() > 0 && (noidle || $urandom_range(99) >= 29)) begin
                    t_cmd c;
                    c = pending_cmds.pop_front();
                    // tdata: op in the low bits, then id, expiry, now.
                    s_axis_tdata <= {c.now, c.expiry, c.id, c.op};
                    s_axis_tvalid <= 1;
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // Results monitor and receiver ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_res got;
                got = mk_res(setl_pkg::t_status'(m_axis_tdata[1:0]), m_axis_tdata[2],
                             m_axis_tdata[8:3], m_axis_tlast);
                results_seen++;
                if (got.exp_valid) expiries_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    t_res want;
                    want = expected_results.pop_front();
                    if (got != want || m_axis_tdata[15:9] != 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            m_axis_tready <= !hold_rx && (noidle || $urandom_range(99) >= 29);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || hold_rx)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [5:0] id;
        for (int i = 0; i < 64; i++) present[i] = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty tick, errors, equal expiries, extremes.
        queue_cmd(setl_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
        queue_cmd(setl_pkg::OP_DELETE, 6'd63, 0, 0);
        queue_cmd(setl_pkg::OP_ADJUST, 6'd0, 32'd5, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd63, 32'hFFFF_FFFF, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd0, 32'd0, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd0, 32'd9, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd21, 32'd100, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd42, 32'd100, 0);
        queue_cmd(setl_pkg::OP_ADJUST, 6'd0, 32'd100, 0);
        queue_cmd(setl_pkg::OP_ADJUST, 6'd42, 32'd1, 0);
        queue_cmd(setl_pkg::OP_TICK, 0, 0, 32'd0);
        queue_cmd(setl_pkg::OP_TICK, 0, 0, 32'd100);
        queue_cmd(setl_pkg::OP_DELETE, 6'd63, 0, 0);
        queue_cmd(setl_pkg::OP_DELETE, 6'd63, 0, 0);
        queue_cmd(setl_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
        // Fill the list to capacity, then one more add fails.
        for (int i = 0; i < 64; i++) queue_cmd(setl_pkg::OP_ADD, 6'(i), $urandom, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd7, 32'd1, 0);
        queue_cmd(setl_pkg::OP_DELETE, 6'd7, 0, 0);
        queue_cmd(setl_pkg::OP_ADD, 6'd7, 32'hAAAA_5555, 0);
        queue_cmd(setl_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);

        // Random: mostly small id and time ranges so operations hit live timers.
        for (int i = 0; i < N_RANDOM; i++) begin
            int k;
            logic [31:0] ex;
            k = $urandom_range(99);
            id = (k < 85) ? 6'($urandom_range(15)) : 6'($urandom);
            ex = (k < 80) ? 32'($urandom_range(1000)) : $urandom;
            if (k < 40) queue_cmd(setl_pkg::OP_ADD, id, ex, 0);
            else if (k < 58) queue_cmd(setl_pkg::OP_ADJUST, id, ex, $urandom);
            else if (k < 75) queue_cmd(setl_pkg::OP_DELETE, id, $urandom, $urandom);
            else queue_cmd(setl_pkg::OP_TICK, 6'($urandom), $urandom,
                           (k < 95) ? 32'($urandom_range(1000)) : $urandom);
        end
        queue_cmd(setl_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);

        // Let the receiver stall for a long stretch while items keep coming.
        wait (items_sent > 90);
        @(posedge i_clk);
        hold_rx <= 1;
        repeat (300) @(posedge i_clk);
        hold_rx <= 0;
        noidle <= 1;
        repeat (400) @(posedge i_clk);
        noidle <= 0;

        wait (pending_cmds.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("Ran %0d items; %0d results checked, %0d of them expiries.",
                 items_sent, results_seen, expiries_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
